FILE: rtl/cnbq_pkg.sv
// Shared types and constants of the two-channel cascaded notch filter core.
// Holds section/channel counts, datapath widths and the history row layout.
// No dependencies.
package cnbq_pkg;

    // Filter shape
    localparam int NUM_SECTIONS = 4;
    localparam int NUM_CHANNELS = 2;
    localparam int NUM_REGS     = 8;          // two coefficient words per section slot
    localparam int COEF_SLOTS   = NUM_REGS / 2;

    // Widths
    localparam int SAMPLE_W  = 16;
    localparam int DATA_W    = 24;            // Q20.4
    localparam int COEF_W    = 32;            // Q2.30
    localparam int WORD_W    = 64;
    localparam int PROD_W    = COEF_W + DATA_W;
    localparam int ACC_W     = PROD_W + 3;    // five products summed exactly
    localparam int FRAC_W    = 30;
    localparam int ROUND_W   = ACC_W - FRAC_W;
    localparam int CFG_IDX_W = 4;
    localparam int SLOT_W    = $clog2(COEF_SLOTS);
    localparam int SEC_W     = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int CH_W      = 1;
    localparam int DEPTH     = NUM_CHANNELS * NUM_SECTIONS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int S_TDATA_W = 2 * SAMPLE_W;
    localparam int M_TDATA_W = 2 * DATA_W;

    // Saturation bounds
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // One history row per (channel, section)
    typedef struct packed {
        logic signed [DATA_W-1:0] y2;
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W-1:0] x2;
        logic signed [DATA_W-1:0] x1;
    } t_hist;

endpackage

FILE: rtl/cascaded_notch_biquad_two_channel_core.sv
// Top level of the two-channel cascaded notch filter core.
// Depends on cnbq_pkg (widths, history row type).
//
// Usage:
//  - Input stream (s_tvalid/s_tready/s_tdata) carries one ADC code per channel.
//    Each channel runs through NUM_SECTIONS second-order notch sections.
//  - Output stream (m_tvalid/m_tready/m_tdata) gives both filtered samples,
//    signed Q20.4, saturated, one result per input transfer.
//  - Config write channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data)
//    loads the coefficient words; index 2*s is section s+1 {K, a1}, index 2*s+1
//    is {b1, b2}. Indexes beyond the list are ignored. Write only when idle.
//  - One shared 32x24 multiplier does all work. Each section runs in steps:
//    one history read, five products plus one accumulate drain, one round and
//    write-back. An item passes through all NUM_CHANNELS * NUM_SECTIONS
//    sections in turn; a new item is taken only after the result of the last
//    has moved to the output register.
//  - History for every (channel, section) lives in one synchronous memory of
//    NUM_CHANNELS*NUM_SECTIONS rows; per-row valid bits make rows read as zero
//    after reset, so no clearing pass is needed.
//  - Reset (i_rst_n low, synchronous) clears coefficients, history valid bits
//    and all control state.
//  - A stalled receiver holds the result in the output register; the next item
//    is still accepted and computed, then waits until the output frees up.
module cascaded_notch_biquad_two_channel_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cnbq_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] sample_a, [31:16] sample_b
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cnbq_pkg::M_TDATA_W-1:0]      m_tdata,   // [23:0] filtered_a, [47:24] filtered_b
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cnbq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cnbq_pkg::WORD_W-1:0]         i_cfg_data
);
    import cnbq_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // MAC steps: each names the product issued in that step
    localparam logic [2:0] STEP_K_X   = 3'd0;
    localparam logic [2:0] STEP_A1_X1 = 3'd1;
    localparam logic [2:0] STEP_K_X2  = 3'd2;
    localparam logic [2:0] STEP_B1_Y1 = 3'd3;
    localparam logic [2:0] STEP_B2_Y2 = 3'd4;
    localparam logic [2:0] STEP_DRAIN = 3'd5;

    logic [2:0]               r_state, n_state;
    logic [2:0]               r_step;
    logic [CH_W-1:0]          r_ch;
    logic [SEC_W-1:0]         r_sec;
    logic signed [DATA_W-1:0] r_x;
    logic [SAMPLE_W-1:0]      r_samp_b;
    logic signed [DATA_W-1:0] r_res_a, r_res_b;
    logic                     r_out_vld;
    logic [M_TDATA_W-1:0]     r_out_data;

    logic [WORD_W-1:0]        r_zero [COEF_SLOTS];
    logic [WORD_W-1:0]        r_pole [COEF_SLOTS];

    t_hist                    mem [DEPTH];
    logic [DEPTH-1:0]         r_vld;
    t_hist                    r_rd_data;
    logic                     r_rd_vld;
    t_hist                    w_hist;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_sub;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;

    logic [ADDR_W-1:0]        w_addr;
    logic [SLOT_W-1:0]        w_slot;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [DATA_W-1:0] w_opnd;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_rsum;
    logic signed [ROUND_W-1:0] w_rnd;
    logic signed [DATA_W-1:0] w_y;
    logic                     w_sec_last, w_ch_last, w_out_free, w_in_xfer;

    assign w_in_xfer  = s_tvalid && s_tready;
    assign w_out_free = !r_out_vld || m_tready;
    assign w_sec_last = (r_sec == SEC_W'(NUM_SECTIONS - 1));
    assign w_ch_last  = (r_ch == CH_W'(NUM_CHANNELS - 1));
    assign w_addr     = ADDR_W'(r_ch) * ADDR_W'(NUM_SECTIONS) + ADDR_W'(r_sec);
    assign w_slot     = SLOT_W'(r_sec);
    assign w_hist     = r_rd_vld ? r_rd_data : '0;

    // Port handshakes
    assign s_tready    = (r_state == S_IDLE);
    assign m_tvalid    = r_out_vld;
    assign m_tdata     = r_out_data;
    assign o_cfg_ready = 1'b1;

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COEF_SLOTS; i++) begin
                r_zero[i] <= '0;
                r_pole[i] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            if (i_cfg_index[0]) begin
                r_pole[i_cfg_index[SLOT_W:1]] <= i_cfg_data;
            end else begin
                r_zero[i_cfg_index[SLOT_W:1]] <= i_cfg_data;
            end
        end
    end

    // Pick the operand pair for the current MAC step
    always_comb begin
        unique case (r_step)
            STEP_K_X:   begin w_coef = r_zero[w_slot][63:32]; w_opnd = r_x;       end
            STEP_A1_X1: begin w_coef = r_zero[w_slot][31:0];  w_opnd = w_hist.x1; end
            STEP_K_X2:  begin w_coef = r_zero[w_slot][63:32]; w_opnd = w_hist.x2; end
            STEP_B1_Y1: begin w_coef = r_pole[w_slot][63:32]; w_opnd = w_hist.y1; end
            STEP_B2_Y2: begin w_coef = r_pole[w_slot][31:0];  w_opnd = w_hist.y2; end
            default:    begin w_coef = '0;                    w_opnd = '0;        end
        endcase
    end

    assign w_prod     = w_coef * w_opnd;
    assign w_prod_ext = ACC_W'(r_prod);

    // Round half up to Q20.4, then saturate
    assign w_rsum = r_acc + (ACC_W'(1) <<< (FRAC_W - 1));
    assign w_rnd  = w_rsum[ACC_W-1:FRAC_W];
    always_comb begin
        priority if (w_rnd > ROUND_W'(SAT_MAX)) begin
            w_y = SAT_MAX;
        end else if (w_rnd < ROUND_W'(SAT_MIN)) begin
            w_y = SAT_MIN;
        end else begin
            w_y = w_rnd[DATA_W-1:0];
        end
    end

    // History memory: registered read in READ, write-back in FIN
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_data <= mem[w_addr];
        end
        if (r_state == S_FIN) begin
            mem[w_addr] <= '{y2: w_hist.y1, y1: w_y, x2: w_hist.x1, x1: r_x};
        end
    end

    // Row valid bits: unwritten rows read as zero history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (r_state == S_READ) begin
                r_rd_vld <= r_vld[w_addr];
            end
            if (r_state == S_FIN) begin
                r_vld[w_addr] <= 1'b1;
            end
        end
    end

    // Multiplier and accumulator
    always_ff @(posedge i_clk) begin
        if (r_state == S_MAC) begin
            r_prod <= w_prod;
            r_sub  <= (r_step == STEP_A1_X1) || (r_step == STEP_B2_Y2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= (r_state == S_MAC) && (r_step != STEP_DRAIN);
            if (r_state == S_READ) begin
                r_acc <= '0;
            end else if (r_prod_vld) begin
                r_acc <= r_sub ? (r_acc - w_prod_ext) : (r_acc + w_prod_ext);
            end
        end
    end

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_xfer) n_state = S_READ;
            S_READ: n_state = S_MAC;
            S_MAC:  if (r_step == STEP_DRAIN) n_state = S_FIN;
            S_FIN: begin
                if (w_sec_last && w_ch_last) n_state = S_DONE;
                else                         n_state = S_READ;
            end
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer: channel, section and step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_K_X;
            r_ch    <= '0;
            r_sec   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_ch  <= '0;
                    r_sec <= '0;
                end
                S_READ: r_step <= STEP_K_X;
                S_MAC:  r_step <= r_step + 3'd1;
                S_FIN: begin
                    if (w_sec_last) begin
                        r_sec <= '0;
                        if (!w_ch_last) r_ch <= r_ch + CH_W'(1);
                    end else begin
                        r_sec <= r_sec + SEC_W'(1);
                    end
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    // Section input and per-channel results
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_x      <= {4'b0, s_tdata[SAMPLE_W-1:0], 4'b0};
            r_samp_b <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            r_res_a  <= '0;
            r_res_b  <= '0;
        end else if (r_state == S_FIN) begin
            if (w_sec_last) begin
                r_x <= {4'b0, r_samp_b, 4'b0};
                if (r_ch == '0) r_res_a <= w_y;
                else            r_res_b <= w_y;
            end else begin
                r_x <= w_y;
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_data <= {r_res_b, r_res_a};
        end
    end

    // Checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_READ) && (r_ch == '0) && (r_sec == '0))
        else $error("item did not start at channel 0, section 0");

    a_drain_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) && (r_step == STEP_DRAIN) |=> (r_state == S_FIN))
        else $error("MAC drain did not lead to write-back");

    a_fin_after_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> ($past(r_state) == S_MAC))
        else $error("write-back without a finished accumulation");

    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && w_out_free |=> r_out_vld && (r_state == S_IDLE))
        else $error("finished item not moved to output register");

endmodule

FILE: test/tb_top.sv
// Self-checking bench for the two-channel cascaded notch filter core.
// Models the four-section fixed-point cascade per channel; needs cnbq_pkg and the core RTL.
// Drives the sample stream and the coefficient port, checks each filtered pair in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cnbq_pkg::*;

    localparam int RANDOM_BLOCKS  = 6;
    localparam int BLOCK_ITEMS    = 125;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 150;
    localparam int ZERO_WORD      = 0;    // {K, a1} word of a section
    localparam int POLE_WORD      = 1;    // {b1, b2} word of a section

    typedef struct packed {
        logic [SAMPLE_W-1:0] code_b;
        logic [SAMPLE_W-1:0] code_a;
    } t_adc_pair;

    typedef struct packed {
        logic signed [DATA_W-1:0] filt_b;
        logic signed [DATA_W-1:0] filt_a;
    } t_filt_pair;

    typedef enum int {COEF_NOTCH, COEF_SMALL, COEF_WILD} t_coef_style;

    // Clock and DUT ports
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;   // [15:0] sample_a, [31:16] sample_b
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;            // [23:0] filtered_a, [47:24] filtered_b
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [WORD_W-1:0]      i_cfg_data  = '0;

    // Bench model state: coefficient words and per-section history
    logic [WORD_W-1:0]        coeff_word [NUM_REGS];
    logic signed [DATA_W-1:0] hist_x1 [NUM_CHANNELS][NUM_SECTIONS];
    logic signed [DATA_W-1:0] hist_x2 [NUM_CHANNELS][NUM_SECTIONS];
    logic signed [DATA_W-1:0] hist_y1 [NUM_CHANNELS][NUM_SECTIONS];
    logic signed [DATA_W-1:0] hist_y2 [NUM_CHANNELS][NUM_SECTIONS];

    t_adc_pair  adc_backlog [$];
    t_filt_pair filtered_due [$];

    int src_gap_pct   = 0;
    int sink_gap_pct  = 0;
    int hold_req      = 0;
    int hold_ack      = 0;
    int rx_hold_left  = 0;
    int quiet_cycles  = 0;
    int samples_sent  = 0;
    int pairs_checked = 0;
    int coeff_writes  = 0;
    int mismatches    = 0;
    t_filt_pair want, got;

    cascaded_notch_biquad_two_channel_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // One notch section: exact sum of five products, round half up, saturate
    function automatic logic signed [DATA_W-1:0] run_notch(int ch, int sec,
                                                           logic signed [DATA_W-1:0] x);
        logic signed [COEF_W-1:0] k, a1, b1, b2;
        longint acc, rounded;
        logic signed [DATA_W-1:0] y;
        k  = coeff_word[2*sec + ZERO_WORD][63:32];
        a1 = coeff_word[2*sec + ZERO_WORD][31:0];
        b1 = coeff_word[2*sec + POLE_WORD][63:32];
        b2 = coeff_word[2*sec + POLE_WORD][31:0];
        acc = longint'(k)  * longint'(x)
            - longint'(a1) * longint'(hist_x1[ch][sec])
            + longint'(k)  * longint'(hist_x2[ch][sec])
            + longint'(b1) * longint'(hist_y1[ch][sec])
            - longint'(b2) * longint'(hist_y2[ch][sec]);
        rounded = (acc + (longint'(1) <<< 29)) >>> 30;
        if (rounded > longint'(SAT_MAX))
            y = SAT_MAX;
        else if (rounded < longint'(SAT_MIN))
            y = SAT_MIN;
        else
            y = DATA_W'(rounded);
        hist_x2[ch][sec] = hist_x1[ch][sec];
        hist_x1[ch][sec] = x;
        hist_y2[ch][sec] = hist_y1[ch][sec];
        hist_y1[ch][sec] = y;
        return y;
    endfunction

    // Filter both channels through the whole cascade
    function automatic t_filt_pair predict_notch_cascade(t_adc_pair item);
        t_filt_pair res;
        logic signed [DATA_W-1:0] v;
        logic [SAMPLE_W-1:0] code;
        res = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            code = (ch == 0) ? item.code_a : item.code_b;
            v = {4'b0000, code, 4'b0000};
            for (int sec = 0; sec < NUM_SECTIONS; sec++)
                v = run_notch(ch, sec, v);
            if (ch == 0)
                res.filt_a = v;
            else
                res.filt_b = v;
        end
        return res;
    endfunction

    function automatic logic [COEF_W-1:0] to_q230(real v);
        return COEF_W'($rtoi(v * 1073741824.0));
    endfunction

    function automatic real rand_span(real span);
        return span * (real'($urandom_range(20000)) - 10000.0) / 10000.0;
    endfunction

    function automatic void queue_pair(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
        adc_backlog.insert(adc_backlog.size(), '{code_b: b, code_a: a});
    endfunction

    // Write one coefficient register and mirror it into the model
    task automatic load_coeff(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] word);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx < NUM_REGS)
            coeff_word[idx] = word;
        coeff_writes++;
    endtask

    task automatic load_section(int sec, logic [WORD_W-1:0] zw, logic [WORD_W-1:0] pw);
        load_coeff(CFG_IDX_W'(2*sec + ZERO_WORD), zw);
        load_coeff(CFG_IDX_W'(2*sec + POLE_WORD), pw);
    endtask

    task automatic load_all(logic [WORD_W-1:0] zw, logic [WORD_W-1:0] pw);
        for (int sec = 0; sec < NUM_SECTIONS; sec++)
            load_section(sec, zw, pw);
    endtask

    // Hold off until every queued sample went in and every pair came back
    task automatic await_drain();
        while (adc_backlog.size() != 0 || s_tvalid || filtered_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Sample stream driver: hold while stalled, otherwise offer or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                filtered_due.insert(filtered_due.size(),
                                    predict_notch_cascade(t_adc_pair'(s_tdata)));
                samples_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (adc_backlog.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                    s_tdata  <= adc_backlog.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = t_filt_pair'(m_tdata);
                if (filtered_due.size() == 0) begin
                    $error("filtered pair %h with no sample pending", m_tdata);
                    mismatches++;
                end else begin
                    want = filtered_due.pop_front();
                    pairs_checked++;
                    if (got.filt_a !== want.filt_a) begin
                        $error("filtered_a: expected %0d, got %0d", want.filt_a, got.filt_a);
                        mismatches++;
                    end
                    if (got.filt_b !== want.filt_b) begin
                        $error("filtered_b: expected %0d, got %0d", want.filt_b, got.filt_b);
                        mismatches++;
                    end
                end
            end
            // Long back-pressure on request, otherwise random stalls
            if (rx_hold_left > 0) begin
                rx_hold_left <= rx_hold_left - 1;
                m_tready     <= 1'b0;
            end else if (hold_ack != hold_req) begin
                hold_ack     <= hold_req;
                rx_hold_left <= RX_HOLD_CYCLES;
                m_tready     <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_gap_pct);
            end
        end
    end

    // Watchdog: abort when no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [WORD_W-1:0] zw, pw;
        real w, r, g;
        t_adc_pair item;
        t_coef_style style;
        int pick;

        for (int i = 0; i < NUM_REGS; i++)
            coeff_word[i] = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            for (int sec = 0; sec < NUM_SECTIONS; sec++) begin
                hist_x1[ch][sec] = '0;
                hist_x2[ch][sec] = '0;
                hist_y1[ch][sec] = '0;
                hist_y2[ch][sec] = '0;
            end
        end
        item = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_gap_pct  = 17;
        sink_gap_pct = 57;

        // Coefficients at reset value: everything filters to zero
        queue_pair(16'h0000, 16'hFFFF);
        queue_pair(16'hFFFF, 16'h0000);
        queue_pair(16'h8000, 16'h7FFF);
        await_drain();

        // K of one, no poles: each section adds its input from two items back
        load_all({to_q230(1.0), 32'h0}, 64'h0);
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'hFFFF, 16'hFFFF);
        queue_pair(16'h0000, 16'hFFFF);
        queue_pair(16'hFFFF, 16'h0000);
        queue_pair(16'h8000, 16'h7FFF);
        queue_pair(16'h0001, 16'hFFFE);
        queue_pair(16'h5555, 16'hAAAA);
        queue_pair(16'hAAAA, 16'h5555);
        await_drain();

        // Extreme coefficients: drive toward positive saturation
        load_all({32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000});
        queue_pair(16'hFFFF, 16'h0001);
        queue_pair(16'hFFFF, 16'hFFFF);
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'h1234, 16'hFEDC);
        await_drain();

        // Extreme coefficients of the other sign: swing to both rails
        load_all({32'h8000_0000, 32'h7FFF_FFFF}, {32'h8000_0000, 32'h7FFF_FFFF});
        queue_pair(16'hFFFF, 16'hFFFF);
        queue_pair(16'h0001, 16'h8000);
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'hFFFF, 16'h0000);
        await_drain();

        // All-ones words: every coefficient is minus one LSB
        load_all('1, '1);
        load_coeff(CFG_IDX_W'(NUM_REGS), 64'hDEAD_BEEF_0123_4567);
        load_coeff('1, '1);
        queue_pair(16'hFFFF, 16'hFFFF);
        queue_pair(16'h7FFF, 16'h8000);
        queue_pair(16'h0000, 16'hFFFF);
        await_drain();

        // Random blocks, each with its own coefficient set; each pair of blocks shares one idle mix
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            case (blk / 2)
                0: begin
                    src_gap_pct  = 17;
                    sink_gap_pct = 57;
                end
                1: begin
                    src_gap_pct  = 57;
                    sink_gap_pct = 17;
                end
                default: begin
                    src_gap_pct  = 0;
                    sink_gap_pct = 0;
                end
            endcase
            style = t_coef_style'(blk % 3);
            for (int sec = 0; sec < NUM_SECTIONS; sec++) begin
                case (style)
                    COEF_NOTCH: begin
                        w  = 3.14159 * real'($urandom_range(5, 995)) / 1000.0;
                        r  = 0.80 + 0.19 * real'($urandom_range(1000)) / 1000.0;
                        g  = (1.0 + r * r) / 2.0;
                        zw = {to_q230(g), to_q230(2.0 * g * $cos(w))};
                        pw = {to_q230(2.0 * r * $cos(w)), to_q230(r * r)};
                    end
                    COEF_SMALL: begin
                        zw = {to_q230(rand_span(1.0)), to_q230(rand_span(1.9))};
                        pw = {to_q230(rand_span(1.9)), to_q230(rand_span(0.95))};
                    end
                    default: begin
                        zw = {$urandom, $urandom};
                        pw = {$urandom, $urandom};
                    end
                endcase
                load_section(sec, zw, pw);
            end
            // Out-of-range index must be ignored
            load_coeff(CFG_IDX_W'(NUM_REGS + $urandom_range(NUM_REGS - 1)), {$urandom, $urandom});

            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    item.code_a = $urandom_range(1) ? '1 : '0;
                    item.code_b = $urandom_range(1) ? '1 : '0;
                end else if (pick >= 30) begin
                    item = t_adc_pair'($urandom);
                end
                // else repeat the last pair for a short DC run
                adc_backlog.insert(adc_backlog.size(), item);
            end
            // Stall the output long enough to back the core up into its input
            if (blk == RANDOM_BLOCKS - 1)
                hold_req++;
            await_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (filtered_due.size() != 0) begin
            $error("%0d filtered pairs never arrived", filtered_due.size());
            mismatches++;
        end
        $display("Run: %0d sample pairs in, %0d filtered pairs checked, %0d coefficient writes.",
                 samples_sent, pairs_checked, coeff_writes);
        $display("Sets: reset, unit K, both saturating extremes, all-ones, notch, small, wild.");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cnbq_pkg.sv
rtl/cascaded_notch_biquad_two_channel_core.sv
test/tb_top.sv
